[src/fifo_queue_remove_by_value_defines.svh]
// Assertion macros for the FIFO queue with delete by value.
// Used by the top level; expects clk and rst_n in scope.
`ifndef FIFO_QUEUE_REMOVE_BY_VALUE_DEFINES_SVH
`define FIFO_QUEUE_REMOVE_BY_VALUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FQRBV_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FQRBV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fqrbv_pkg.sv]
// Shared types and codes for the FIFO queue with delete by value.
// No dependencies.
package fqrbv_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data_out;
    logic [OCC_W-1:0]         occupancy;
  } out_item_t;

endpackage

[src/fifo_queue_remove_by_value.sv]
// Bounded FIFO queue of signed 32-bit words with push, pop and delete by value, held
// compacted oldest-first in one RAM of DEPTH words (one write and one registered read
// port). One result per item. Push, a full push, a pop of an empty queue and the unused
// kind code go straight to the done state, which then loads the output register. Pop and
// remove read the stored words one per cycle from the oldest until a match, then move
// each newer word down one place through the same read port; the single RAM read port
// sets this pace. A new item is taken only once the previous one has finished, while
// its result may still wait in the output register.
`include "fifo_queue_remove_by_value_defines.svh"

module fifo_queue_remove_by_value
  import fqrbv_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            fill_r, fill_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic                     pend_r, pend_nxt;
  logic [AW-1:0]            pend_idx_r, pend_idx_nxt;
  logic                     pop_r, pop_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [1:0]               status_r, status_nxt;
  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;

  logic          hit;
  logic          idx_lt;
  logic [CW-1:0] idx_m1;
  logic          ram_both;
  logic          push_ok;

  fqrbv_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign hit    = pend_r && (pop_r || (ram_rd_data == value_r));
  assign idx_lt = idx_r < fill_r;
  assign idx_m1 = idx_r - CW'(1);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    pop_nxt       = pop_r;
    value_nxt     = value_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = pend_idx_r;
    ram_wr_data   = ram_rd_data;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = idx_r[AW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt  = in_data.value;
          pop_nxt    = (in_data.kind == KIND_POP);
          data_nxt   = '0;
          idx_nxt    = '0;
          pend_nxt   = 1'b0;
          status_nxt = ST_DONE;
          state_nxt  = S_DONE;
          if (in_data.kind == KIND_PUSH) begin
            if (fill_r == CW'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              ram_wr_en   = 1'b1;
              ram_wr_addr = fill_r[AW-1:0];
              ram_wr_data = in_data.value;
              fill_nxt    = fill_r + CW'(1);
            end
          end else if (in_data.kind == KIND_POP) begin
            if (fill_r == '0) begin
              status_nxt = ST_EMPTY;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (in_data.kind == KIND_REMOVE) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_rd_en = idx_lt;
        if (hit) begin
          idx_nxt   = CW'(pend_idx_r) + CW'(1);
          pend_nxt  = 1'b0;
          state_nxt = S_SHIFT;
          if (pop_r) begin
            data_nxt = ram_rd_data;
          end
        end else if (!pend_r && !idx_lt) begin
          status_nxt = ST_MISSING;
          state_nxt  = S_DONE;
        end else begin
          pend_nxt     = idx_lt;
          pend_idx_nxt = idx_r[AW-1:0];
          if (idx_lt) begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      S_SHIFT: begin
        ram_rd_en = idx_lt;
        ram_wr_en = pend_r;
        if (!pend_r && !idx_lt) begin
          fill_nxt  = fill_r - CW'(1);
          state_nxt = S_DONE;
        end else begin
          pend_nxt     = idx_lt;
          pend_idx_nxt = idx_m1[AW-1:0];
          if (idx_lt) begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = status_r;
          out_data_nxt.data_out  = data_r;
          out_data_nxt.occupancy = OCC_W'(fill_r);
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    pop_r      <= pop_nxt;
    value_r    <= value_nxt;
    status_r   <= status_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign ram_both = ram_wr_en && ram_rd_en;
  assign push_ok  = (state_r == S_IDLE) && in_valid && (in_data.kind == KIND_PUSH) &&
                    (fill_r != CW'(DEPTH));

  `FQRBV_ASSERT(a_fill_bound, 1'b1, fill_r <= CW'(DEPTH), "fill count above depth")
  `FQRBV_ASSERT(a_ram_no_overlap, ram_both, ram_wr_addr != ram_rd_addr, "RAM port clash")
  `FQRBV_ASSERT_NEXT(a_push_grows, push_ok, fill_r == $past(fill_r) + CW'(1), "push lost")

endmodule

[src/fqrbv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqrbv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[bench/fifo_queue_remove_by_value_tb.sv]
// Testbench for fifo_queue_remove_by_value: push, pop and delete-by-value traffic
// checked against an in-bench queue predictor, with random idling and back pressure.
// Depends on fqrbv_pkg and the fifo_queue_remove_by_value RTL.
`timescale 1ns / 100ps

module fifo_queue_remove_by_value_tb;
  import fqrbv_pkg::*;

  localparam int DEPTH = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic signed [DATA_W-1:0] held_words[$];
  out_item_t                pending_results[$];
  out_item_t                want;
  logic signed [DATA_W-1:0] tail_word;
  int errors = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  int hold_request = 0;
  bit stall_enable = 1'b0;
  bit send_idle = 1'b0;

  fifo_queue_remove_by_value #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] random_word();
    if ($urandom_range(0, 99) < 30) return int'($urandom_range(0, 8)) - 4;
    return $urandom();
  endfunction

  function automatic out_item_t apply_queue_op(in_item_t op);
    out_item_t res;
    int hit;
    res = '{status: ST_DONE, data_out: '0, occupancy: '0};
    hit = -1;
    case (op.kind)
      KIND_PUSH: begin
        if (held_words.size() >= DEPTH) res.status = ST_FULL;
        else held_words.push_back(op.value);
      end
      KIND_POP: begin
        if (held_words.size() == 0) res.status = ST_EMPTY;
        else res.data_out = held_words.pop_front();
      end
      KIND_REMOVE: begin
        for (int k = 0; k < held_words.size() && hit < 0; k++)
          if (held_words[k] == op.value) hit = k;
        if (hit < 0) res.status = ST_MISSING;
        else held_words.delete(hit);
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(held_words.size());
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) pending_results.push_back(apply_queue_op(in_data));
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          errors++;
        end
        if (out_data.data_out !== want.data_out) begin
          $display("%0t: data_out expected %0d actual %0d", $time, want.data_out,
                   out_data.data_out);
          errors++;
        end
        if (out_data.occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
                   out_data.occupancy);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (stall_enable && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
      end
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("fifo_queue_remove_by_value_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic send_op(input logic [1:0] op, input logic signed [DATA_W-1:0] word);
    int gap;
    gap = (send_idle && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    in_data <= '{kind: op, value: word};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_op(KIND_POP, 32'sd0);
    send_op(KIND_REMOVE, 32'sd7);
    send_op(KIND_UNUSED, -32'sd1);
  endtask

  task automatic test_fill_to_full();
    logic signed [DATA_W-1:0] corner_words [8];
    corner_words = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1,
                     32'shaaaa_aaaa, 32'sh5555_5555, 32'sd1, 32'sh8000_0000};
    foreach (corner_words[i]) send_op(KIND_PUSH, corner_words[i]);
    for (int i = 0; i < 8; i++) begin
      tail_word = $urandom();
      send_op(KIND_PUSH, tail_word);
    end
    send_op(KIND_PUSH, 32'sh7fff_ffff);
  endtask

  task automatic test_remove_positions();
    send_op(KIND_REMOVE, 32'sh8000_0000);
    send_op(KIND_REMOVE, tail_word);
    send_op(KIND_REMOVE, 32'sh5555_5555);
    send_op(KIND_REMOVE, 32'sh1234_5678);
    send_op(KIND_POP, 32'sd0);
  endtask

  task automatic test_back_pressure();
    send_idle = 1'b0;
    stall_enable = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int i = 0; i < 48; i++) send_op((i % 4 == 3) ? KIND_POP : KIND_PUSH, random_word());
  endtask

  task automatic test_random_traffic(input int count, input bit sender_gaps,
                                     input bit receiver_stalls);
    bit filling;
    int roll;
    logic [1:0] op;
    logic signed [DATA_W-1:0] word;
    filling = 1'b1;
    send_idle = sender_gaps;
    stall_enable = receiver_stalls;
    for (int i = 0; i < count; i++) begin
      if (held_words.size() >= DEPTH) filling = 1'b0;
      else if (held_words.size() == 0) filling = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 4) op = KIND_UNUSED;
      else if (roll < (filling ? 64 : 28)) op = KIND_PUSH;
      else if (roll < (filling ? 78 : 60)) op = KIND_POP;
      else op = KIND_REMOVE;
      word = random_word();
      if (op == KIND_REMOVE && held_words.size() > 0 && $urandom_range(0, 99) < 70)
        word = held_words[$urandom_range(0, held_words.size() - 1)];
      send_op(op, word);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_fill_to_full();
    test_remove_positions();
    test_back_pressure();
    drain_results();
    test_random_traffic(300, 1'b0, 1'b0);
    test_random_traffic(360, 1'b1, 1'b1);
    drain_results();
    test_random_traffic(360, 1'b0, 1'b1);
    test_random_traffic(360, 1'b1, 1'b0);
    drain_results();
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("fifo_queue_remove_by_value_tb: done, clean");
    end else begin
      $display("fifo_queue_remove_by_value_tb: done, errors");
    end
    $finish;
  end

endmodule
